// ----- hdl/rounded_rect_alpha_blender_defines.svh -----
// Assertion macros for the rounded rectangle alpha blender.
`ifndef ROUNDED_RECT_ALPHA_BLENDER_DEFINES_SVH
`define ROUNDED_RECT_ALPHA_BLENDER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked out of reset: property disabled while rst_n is low.
`define RRAB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RRAB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRAB_ASSERT(label, clk, rst_n, prop, msg)
`define RRAB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hdl/rrab_pkg.sv -----
// Types, constants and blend helpers for the rounded rectangle alpha blender.
`default_nettype none

package rrab_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned RADIUS_W   = 6;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned ALPHA_W    = 8;
  localparam int unsigned COL_W      = 9;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // RGB565 field layout
  localparam int unsigned RED_LSB   = 11;
  localparam int unsigned GREEN_LSB = 5;
  localparam int unsigned BLUE_LSB  = 0;
  localparam int unsigned RB_W      = 5;
  localparam int unsigned G_W       = 6;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RECT_LEFT     = 3'd0,
    CFG_RECT_TOP      = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_FILL_COLOR    = 3'd5,
    CFG_BLEND_ALPHA   = 3'd6
  } cfg_idx_t;

  // (f*a + b*(255-a)) / 255, truncated; the sum stays below 2^14 so
  // (x + 1 + (x >> 8)) >> 8 gives the exact quotient.
  function automatic logic [G_W-1:0] mix_chan(input logic [G_W-1:0] f,
                                               input logic [G_W-1:0] b,
                                               input logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] ia;
    logic [13:0]        pf;
    logic [13:0]        pb;
    logic [13:0]        sum;
    logic [14:0]        t;
    ia  = ALPHA_MAX - a;
    pf  = {8'b0, f} * {6'b0, a};
    pb  = {8'b0, b} * {6'b0, ia};
    sum = pf + pb;
    t   = {1'b0, sum} + 15'd1 + {9'b0, sum[13:8]};
    return t[13:8];
  endfunction

  function automatic logic [COLOR_W-1:0] blend565(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [ALPHA_W-1:0] a);
    logic [G_W-1:0] r;
    logic [G_W-1:0] g;
    logic [G_W-1:0] b;
    r = mix_chan({1'b0, fg[RED_LSB +: RB_W]}, {1'b0, bg[RED_LSB +: RB_W]}, a);
    g = mix_chan(fg[GREEN_LSB +: G_W], bg[GREEN_LSB +: G_W], a);
    b = mix_chan({1'b0, fg[BLUE_LSB +: RB_W]}, {1'b0, bg[BLUE_LSB +: RB_W]}, a);
    return {r[RB_W-1:0], g, b[RB_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rounded_rect_alpha_blender.sv -----
// Rounded rectangle alpha blender: RGB565 pixel stream in, blended stream out.
`default_nettype none
`include "rounded_rect_alpha_blender_defines.svh"

// Takes one pixel per clock, back to back, while out_tready stays high. A pixel
// accepted at the input passes through the input register and then the result
// register before it shows on the output. All coverage and blend math sits in
// one combinational pass between those two registers, so the throughput is
// one pixel per cycle whenever the sink keeps out_tready high.
// A pixel inside the configured rectangle with quarter-circle corners has each
// channel blended as (fill*alpha + bg*(255-alpha))/255, truncated, and carries
// covered = 1 on out_tuser; pixels outside or off screen pass unchanged.
// The user writes cfg_* registers only while the stream is idle; not enforced.
module rounded_rect_alpha_blender
  import rrab_pkg::*;
#(
  parameter int unsigned SCREEN_COLS = 320,
  parameter int unsigned SCREEN_ROWS = 240
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [8:0] pixel_col, [16:9] pixel_row, [32:17] background_color, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] result_color
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] covered
  output logic [0:0]                 out_tuser
);

  localparam int unsigned CMP_W = 11;

  // configuration
  logic [COORD_W-1:0]  rect_left_r;
  logic [COORD_W-1:0]  rect_top_r;
  logic [COORD_W-1:0]  rect_width_r;
  logic [COORD_W-1:0]  rect_height_r;
  logic [RADIUS_W-1:0] corner_radius_r;
  logic [COLOR_W-1:0]  fill_color_r;
  logic [ALPHA_W-1:0]  blend_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r     <= '0;
      rect_top_r      <= '0;
      rect_width_r    <= '0;
      rect_height_r   <= '0;
      corner_radius_r <= '0;
      fill_color_r    <= '0;
      blend_alpha_r   <= ALPHA_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_RECT_LEFT:     rect_left_r     <= cfg_wdata[COORD_W-1:0];
        CFG_RECT_TOP:      rect_top_r      <= cfg_wdata[COORD_W-1:0];
        CFG_RECT_WIDTH:    rect_width_r    <= cfg_wdata[COORD_W-1:0];
        CFG_RECT_HEIGHT:   rect_height_r   <= cfg_wdata[COORD_W-1:0];
        CFG_CORNER_RADIUS: corner_radius_r <= cfg_wdata[RADIUS_W-1:0];
        CFG_FILL_COLOR:    fill_color_r    <= cfg_wdata[COLOR_W-1:0];
        CFG_BLEND_ALPHA:   blend_alpha_r   <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic               s1_valid_r;
  logic [COL_W-1:0]   s1_col_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [COLOR_W-1:0] s1_bg_r;
  logic               s1_move;
  logic               in_beat;

  // result stage
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_covered_r;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_beat   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_col_r <= in_tdata[COL_W-1:0];
      s1_row_r <= in_tdata[COL_W +: ROW_W];
      s1_bg_r  <= in_tdata[COL_W+ROW_W +: COLOR_W];
    end
  end

  // coverage test, all in 12-bit signed arithmetic
  logic signed [11:0] u, v, w_s, h_s, r_s, mu, mv, cx, cy, dx, dy;
  logic        [12:0] dsq;
  logic        [11:0] rr;
  logic               on_screen, in_box, body, strip, corner_ok, hit;
  logic [COLOR_W-1:0] blended;

  always_comb begin
    u   = $signed({3'b000, s1_col_r}) - $signed({{2{rect_left_r[COORD_W-1]}}, rect_left_r});
    v   = $signed({4'b0000, s1_row_r}) - $signed({{2{rect_top_r[COORD_W-1]}}, rect_top_r});
    w_s = $signed({2'b00, rect_width_r});
    h_s = $signed({2'b00, rect_height_r});
    r_s = $signed({6'b000000, corner_radius_r});
    mu  = w_s - 12'sd1 - u;
    mv  = h_s - 12'sd1 - v;

    // distance into the corner zone; the mirrored side wins when larger
    cx = (u < r_s) ? u : -12'sd1;
    if (mu < r_s && mu > cx) begin
      cx = mu;
    end
    cy = (v < r_s) ? v : -12'sd1;
    if (mv < r_s && mv > cy) begin
      cy = mv;
    end
    dx = r_s - cx;
    dy = r_s - cy;

    dsq = {7'b0, dx[RADIUS_W-1:0]} * {7'b0, dx[RADIUS_W-1:0]}
        + {7'b0, dy[RADIUS_W-1:0]} * {7'b0, dy[RADIUS_W-1:0]};
    rr  = {6'b0, corner_radius_r} * {6'b0, corner_radius_r};

    on_screen = ({{(CMP_W-COL_W){1'b0}}, s1_col_r} < CMP_W'(SCREEN_COLS)) &&
                ({{(CMP_W-ROW_W){1'b0}}, s1_row_r} < CMP_W'(SCREEN_ROWS));
    in_box    = !u[11] && (u < w_s) && !v[11] && (v < h_s);
    body      = (v >= r_s) && (v < h_s - r_s);
    strip     = (u >= r_s) && (u < w_s - r_s);
    corner_ok = !cx[11] && !cy[11] && (dsq <= {1'b0, rr});
    hit       = on_screen && in_box && (body || strip || corner_ok);

    blended   = blend565(fill_color_r, s1_bg_r, blend_alpha_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_color_r   <= hit ? blended : s1_bg_r;
      out_covered_r <= hit;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_color_r;
  assign out_tuser[0] = out_covered_r;

  `RRAB_ASSERT(a_move_fills_out, clk, rst_n, s1_move |=> out_valid_r, "stage beat lost on way to output")
  `RRAB_ASSERT(a_miss_passes_bg, clk, rst_n, (s1_move && !hit) |=> (out_color_r == $past(s1_bg_r)) && !out_covered_r, "uncovered pixel altered")
  `RRAB_ASSERT(a_opaque_is_fill, clk, rst_n, (s1_move && hit && blend_alpha_r == ALPHA_MAX) |=> out_color_r == $past(fill_color_r), "opaque blend differs from fill")
  `RRAB_ASSERT(a_clear_is_bg, clk, rst_n, (s1_move && hit && blend_alpha_r == '0) |=> out_color_r == $past(s1_bg_r), "transparent blend differs from background")
  `RRAB_ASSERT(a_no_overrun, clk, rst_n, (in_beat && s1_valid_r) |-> s1_move, "input stage overwritten")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking stream testbench for the rounded rectangle alpha blender.
module tb;
  import rrab_pkg::*;

  localparam int SCR_COLS   = 320;
  localparam int SCR_ROWS   = 240;
  localparam int STALL_PCT  = 26;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               covered;
  } pix_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  // shadow copy of the shape registers
  logic signed [COORD_W-1:0] shp_left   = '0;
  logic signed [COORD_W-1:0] shp_top    = '0;
  logic [COORD_W-1:0]        shp_width  = '0;
  logic [COORD_W-1:0]        shp_height = '0;
  logic [RADIUS_W-1:0]       shp_radius = '0;
  logic [COLOR_W-1:0]        fill_rgb   = '0;
  logic [ALPHA_W-1:0]        alpha_q    = ALPHA_MAX;

  pix_result_t expected_px[$];
  int          err_count  = 0;
  int          idle_count = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_req   = 1'b0;

  rounded_rect_alpha_blender #(
    .SCREEN_COLS(SCR_COLS),
    .SCREEN_ROWS(SCR_ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  // depth into the corner zone along one axis, -1 when not in one
  function automatic int corner_depth(int pos, int len, int r);
    int best;
    int mirror;
    best   = -1;
    mirror = len - 1 - pos;
    if (pos < r) best = pos;
    if (mirror < r && mirror > best) best = mirror;
    return best;
  endfunction

  function automatic bit pixel_covered(int col, int row);
    int u, v, w, h, r, cx, cy;
    w = shp_width;
    h = shp_height;
    r = shp_radius;
    u = col - int'(shp_left);
    v = row - int'(shp_top);
    if (col >= SCR_COLS || row >= SCR_ROWS) return 1'b0;
    if (u < 0 || u >= w || v < 0 || v >= h) return 1'b0;
    if (v >= r && v < h - r) return 1'b1;
    if (u >= r && u < w - r) return 1'b1;
    cx = corner_depth(u, w, r);
    cy = corner_depth(v, h, r);
    if (cx < 0 || cy < 0) return 1'b0;
    return (r - cx) * (r - cx) + (r - cy) * (r - cy) <= r * r;
  endfunction

  function automatic int chan_mix(int f, int b, int a);
    return (f * a + b * (255 - a)) / 255;
  endfunction

  function automatic logic [COLOR_W-1:0] blend_rgb565(logic [COLOR_W-1:0] fg,
                                                      logic [COLOR_W-1:0] bg,
                                                      logic [ALPHA_W-1:0] a);
    logic [4:0] red;
    logic [5:0] grn;
    logic [4:0] blu;
    red = 5'(chan_mix(fg[15:11], bg[15:11], a));
    grn = 6'(chan_mix(fg[10:5], bg[10:5], a));
    blu = 5'(chan_mix(fg[4:0], bg[4:0], a));
    return {red, grn, blu};
  endfunction

  function automatic pix_result_t predict_pixel(logic [COL_W-1:0] col,
                                                logic [ROW_W-1:0] row,
                                                logic [COLOR_W-1:0] bg);
    pix_result_t res;
    res.covered = pixel_covered(col, row);
    res.color   = res.covered ? blend_rgb565(fill_rgb, bg, alpha_q) : bg;
    return res;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    pix_result_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("unexpected beat color=%h covered=%b",
                                  out_tdata, out_tuser[0]));
      end else begin
        exp_px = expected_px.pop_front();
        if (out_tdata !== exp_px.color)
          report_mismatch($sformatf("result_color got %h want %h",
                                    out_tdata, exp_px.color));
        if (out_tuser[0] !== exp_px.covered)
          report_mismatch($sformatf("covered got %b want %b",
                                    out_tuser[0], exp_px.covered));
      end
    end
  end

  // nothing moving on either side for too long ends the run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_count <= 0;
    end else if (rst_n) begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !rx_idle_en || ($urandom_range(0, 99) >= STALL_PCT);
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                            logic [COLOR_W-1:0] bg);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < STALL_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, bg, row, col};
    do @(posedge clk); while (!in_tready);
    expected_px.push_back(predict_pixel(col, row, bg));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic program_shape(int left, int top, int w, int h, int r,
                               int fill, int alpha);
    wait_drained();
    shp_left   = left[9:0];
    shp_top    = top[9:0];
    shp_width  = w[9:0];
    shp_height = h[9:0];
    shp_radius = r[5:0];
    fill_rgb   = fill[15:0];
    alpha_q    = alpha[7:0];
    write_reg(CFG_RECT_LEFT,     {6'b0, shp_left});
    write_reg(CFG_RECT_TOP,      {6'b0, shp_top});
    write_reg(CFG_RECT_WIDTH,    {6'b0, shp_width});
    write_reg(CFG_RECT_HEIGHT,   {6'b0, shp_height});
    write_reg(CFG_CORNER_RADIUS, {10'b0, shp_radius});
    write_reg(CFG_FILL_COLOR,    fill_rgb);
    write_reg(CFG_BLEND_ALPHA,   {8'b0, alpha_q});
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // coordinate biased toward the shape edges and corner zones
  function automatic int near_coord(int base, int len, int r, int span);
    int pick;
    int pos;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      pos = $urandom_range(0, r + 1);
      if ($urandom_range(0, 1)) pos = len - 1 - pos;
    end else if (pick < 8) begin
      pos = int'($urandom_range(0, len + 3)) - 2;
    end else begin
      return $urandom_range(0, span - 1);
    end
    pos += base;
    if (pos < 0 || pos >= span) pos = $urandom_range(0, span - 1);
    return pos;
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_pixel();
    int col;
    int row;
    col = near_coord(shp_left, shp_width, shp_radius, 512);
    row = near_coord(shp_top, shp_height, shp_radius, 256);
    send_pixel(col[8:0], row[7:0], rand_color());
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    // empty rectangle after reset: all pixels pass through
    send_pixel(9'd0, 8'd0, 16'hFFFF);
    send_pixel(9'd319, 8'd239, 16'h1234);
    send_pixel(9'd0, 8'd0, 16'h0000);
  endtask

  task automatic test_plain_rect();
    program_shape(10, 10, 20, 15, 0, 16'hFFFF, 255);
    send_pixel(9'd10, 8'd10, 16'h0000);
    send_pixel(9'd29, 8'd24, 16'h0000);
    send_pixel(9'd9, 8'd10, 16'h0000);
    send_pixel(9'd30, 8'd24, 16'h0000);
  endtask

  task automatic test_rounded_corners();
    program_shape(50, 40, 40, 30, 8, 16'hF81F, 128);
    send_pixel(9'd50, 8'd40, 16'h07E0);
    send_pixel(9'd53, 8'd43, 16'h07E0);
    send_pixel(9'd50, 8'd48, 16'hFFFF);
    send_pixel(9'd58, 8'd40, 16'h0000);
    send_pixel(9'd89, 8'd69, 16'h5A5A);
  endtask

  task automatic test_small_rect();
    // width and height below twice the radius
    program_shape(100, 100, 5, 3, 10, 16'h001F, 200);
    send_pixel(9'd100, 8'd100, 16'hA5A5);
    send_pixel(9'd102, 8'd101, 16'hA5A5);
    send_pixel(9'd104, 8'd102, 16'hA5A5);
  endtask

  task automatic test_full_screen();
    // first rectangle spans the screen, the second lies past it; off-screen pixels still pass through
    program_shape(-512, -512, 1023, 1023, 63, 16'hFFFF, 0);
    send_pixel(9'd319, 8'd239, 16'h8421);
    send_pixel(9'd320, 8'd10, 16'h8421);
    send_pixel(9'd511, 8'd255, 16'hFFFF);
    send_pixel(9'd5, 8'd240, 16'h0000);
    program_shape(511, 511, 1023, 1023, 63, 16'h0000, 255);
    send_pixel(9'd319, 8'd239, 16'hFFFF);
    send_pixel(9'd0, 8'd0, 16'hFFFF);
  endtask

  task automatic test_random_shapes(int phases, int per_phase);
    int left, top, w, h, r, fill, alpha;
    for (int p = 0; p < phases; p++) begin
      r = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 63 : 0)
                                      : $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1023);
        1:       w = $urandom_range(0, 2 * r);
        default: w = $urandom_range(0, 130);
      endcase
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 1023);
        1:       h = $urandom_range(0, 2 * r);
        default: h = $urandom_range(0, 130);
      endcase
      left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 1023)) - 512
                                         : int'($urandom_range(0, 360)) - 40;
      top  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 1023)) - 512
                                         : int'($urandom_range(0, 280)) - 40;
      fill = rand_color();
      case ($urandom_range(0, 5))
        0:       alpha = 0;
        1:       alpha = 255;
        default: alpha = $urandom_range(0, 255);
      endcase
      program_shape(left, top, w, h, r, fill, alpha);
      for (int k = 0; k < per_phase; k++) send_random_pixel();
    end
  endtask

  task automatic test_no_idle_burst();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_shape(30, 20, 120, 90, 25, 16'h7BEF, 77);
    for (int k = 0; k < 300; k++) send_random_pixel();
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    program_shape(0, 0, 64, 48, 12, 16'hFFE0, 180);
    hold_req = 1'b1;
    for (int k = 0; k < 120; k++) send_random_pixel();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_plain_rect();
    test_rounded_corners();
    test_small_rect();
    test_full_screen();
    test_random_shapes(24, 50);
    test_no_idle_burst();
    test_backpressure();
    test_random_shapes(4, 50);

    wait_drained();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rrab_pkg.sv
hdl/rounded_rect_alpha_blender.sv
verif/tb.sv
